/* src/assert_macros.svh */
// assertion macros used by the rtl top level, two_class_fifo_oldest_first_core
// no dependencies; the bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("ASSERT_ALWAYS check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ASSERT_NEXT check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/tcf_pkg.sv */
// types and codes for the two-class oldest-first fifo
// used by every module of the block but tcf_ram; no dependencies
package tcf_pkg;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DOG = 2'd0,
        KIND_CAT = 2'd1,
        KIND_ANY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_DEQUEUED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_REJECTED = 3'd4
    } status_t;

    // classified operation as it sits in the command queue
    typedef enum logic [2:0] {
        OP_ENQ_DOG,
        OP_ENQ_CAT,
        OP_DEQ_DOG,
        OP_DEQ_CAT,
        OP_DEQ_ANY,
        OP_REJECT
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } bk_state_t;

    typedef struct packed {
        logic       cmd;
        logic [1:0] kind;
        logic [7:0] pet_name;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_name;
        logic [31:0] out_stamp;
        logic        out_kind;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  name;
        logic [31:0] stamp;
    } slot_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] pet_name;
    } op_entry_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic      valid;
        op_entry_t entry;
    } cmdq_t;

endpackage

/* src/two_class_fifo_oldest_first_core.sv */
// two-class fifo with oldest-first dequeue: top level
// depends on tcf_pkg, tcf_front, tcf_back, tcf_ram and assert_macros.svh
//
// usage:
//   a command (req.cmd, req.kind, req.pet_name) is taken on a rising edge with
//   start high and busy low. each transaction gives exactly one result on rsp,
//   marked by done for a single cycle; the receiver must take it then.
//   enqueue dog/cat stores the name with a stamp from a 32-bit arrival counter;
//   dequeue dog/cat pops that class, dequeue any pops the older head (dog on tie)
//   path, with the queue empty and the back end idle: an enqueue, a rejected
//   command or a dequeue of an empty class passes from the command queue to the
//   registered done and rsp; a successful dequeue also passes through the
//   BK_READ state, because the head entry comes out of the store ram with a
//   registered read.
//   the back end handles each command in BK_IDLE and a successful dequeue in
//   BK_IDLE and then BK_READ; a two-entry command queue in front absorbs the
//   difference and busy rises only while that queue is full.
//   reset clears pointers, counts, the arrival counter and the queue; the
//   stores hold no reset value and are only read where written.
`include "assert_macros.svh"
module two_class_fifo_oldest_first_core #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tcf_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output tcf_pkg::rsp_t rsp
);
    import tcf_pkg::*;

    cmdq_t q_head;
    logic  q_pop;
    logic  rsp_fields_zero;

    tcf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .pop   (q_pop),
        .busy  (busy),
        .head  (q_head)
    );

    tcf_back #(.DEPTH(DEPTH)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .pop   (q_pop),
        .done  (done),
        .rsp   (rsp)
    );

    assign rsp_fields_zero = (rsp.out_name == 8'd0) && (rsp.out_stamp == 32'd0) &&
                             !rsp.out_kind;

    `ASSERT_ALWAYS(a_pop_needs_entry, clk, rst_n, !q_pop || q_head.valid)
    `ASSERT_NEXT(a_accept_fills_queue, clk, rst_n, start && !busy, q_head.valid)
    `ASSERT_ALWAYS(a_idle_fields_zero, clk, rst_n, !done || (rsp.status == ST_DEQUEUED) || rsp_fields_zero)

endmodule

/* src/tcf_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module tcf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/tcf_front.sv */
// front end: takes commands, classifies them and holds them in a two-entry queue
// depends on tcf_pkg
module tcf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tcf_pkg::req_t req,
    input  logic          pop,
    output logic          busy,
    output tcf_pkg::cmdq_t head
);
    import tcf_pkg::*;

    op_entry_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    op_entry_t  new_entry;

    function automatic op_t classify(input req_t r);
        op_t op;
        op = OP_REJECT;
        case (r.kind)
            KIND_DOG: op = (r.cmd == CMD_ENQ) ? OP_ENQ_DOG : OP_DEQ_DOG;
            KIND_CAT: op = (r.cmd == CMD_ENQ) ? OP_ENQ_CAT : OP_DEQ_CAT;
            KIND_ANY: op = (r.cmd == CMD_ENQ) ? OP_REJECT : OP_DEQ_ANY;
            default:  op = OP_REJECT;
        endcase
        return op;
    endfunction

    assign busy   = (cnt_reg == 2'd2);
    assign accept = start && !busy;

    always_comb
    begin
        new_entry.op       = classify(req);
        new_entry.pet_name = req.pet_name;
        wr_ptr_next        = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next        = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next           = cnt_reg + {1'b0, accept} - {1'b0, pop};
        head.valid         = (cnt_reg != 2'd0);
        head.entry         = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* src/tcf_back.sv */
// back end: executes queued commands against the dog and cat stores
// depends on tcf_pkg and tcf_ram
module tcf_back #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tcf_pkg::cmdq_t head,
    output logic           pop,
    output logic           done,
    output tcf_pkg::rsp_t  rsp
);
    import tcf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bk_state_t   state_reg, state_next;
    op_t         op_reg, op_next;
    logic [AW-1:0] dog_head_reg, dog_head_next, dog_tail_reg, dog_tail_next;
    logic [AW-1:0] cat_head_reg, cat_head_next, cat_tail_reg, cat_tail_next;
    logic [CW-1:0] dog_count_reg, dog_count_next, cat_count_reg, cat_count_next;
    logic [31:0] counter_reg, counter_next;
    logic        done_reg, done_next;
    rsp_t        rsp_reg, rsp_next;
    logic        dog_we, cat_we;
    slot_t       wr_slot, dog_rd, cat_rd;
    logic        dog_full, cat_full, dog_empty, cat_empty;
    logic [31:0] stamp_diff;
    logic        take_cat;
    slot_t       taken;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    tcf_ram #(.WIDTH($bits(slot_t)), .DEPTH(DEPTH)) u_dog_ram (
        .clk   (clk),
        .we    (dog_we),
        .waddr (dog_tail_reg),
        .wdata (wr_slot),
        .raddr (dog_head_reg),
        .rdata (dog_rd)
    );

    tcf_ram #(.WIDTH($bits(slot_t)), .DEPTH(DEPTH)) u_cat_ram (
        .clk   (clk),
        .we    (cat_we),
        .waddr (cat_tail_reg),
        .wdata (wr_slot),
        .raddr (cat_head_reg),
        .rdata (cat_rd)
    );

    assign dog_full  = (dog_count_reg == CW'(DEPTH));
    assign cat_full  = (cat_count_reg == CW'(DEPTH));
    assign dog_empty = (dog_count_reg == '0);
    assign cat_empty = (cat_count_reg == '0);

    // cat head is older when the wrapped difference is negative; ties go to the dog
    assign stamp_diff = cat_rd.stamp - dog_rd.stamp;

    always_comb
    begin
        // the stamp compare only counts while both classes hold an entry
        take_cat = (op_reg == OP_DEQ_CAT) ||
                   ((op_reg == OP_DEQ_ANY) &&
                    (dog_empty || (!cat_empty && stamp_diff[31])));
        taken    = take_cat ? cat_rd : dog_rd;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        dog_head_next  = dog_head_reg;
        dog_tail_next  = dog_tail_reg;
        cat_head_next  = cat_head_reg;
        cat_tail_next  = cat_tail_reg;
        dog_count_next = dog_count_reg;
        cat_count_next = cat_count_reg;
        counter_next   = counter_reg;
        pop            = 1'b0;
        dog_we         = 1'b0;
        cat_we         = 1'b0;
        done_next      = 1'b0;
        rsp_next       = '0;
        wr_slot.name   = head.entry.pet_name;
        wr_slot.stamp  = counter_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop     = 1'b1;
                    op_next = head.entry.op;
                    case (head.entry.op)
                        OP_ENQ_DOG:
                        begin
                            done_next = 1'b1;
                            if (dog_full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                dog_we          = 1'b1;
                                dog_tail_next   = ptr_inc(dog_tail_reg);
                                dog_count_next  = dog_count_reg + 1'b1;
                                counter_next    = counter_reg + 32'd1;
                                rsp_next.status = ST_ENQUEUED;
                            end
                        end
                        OP_ENQ_CAT:
                        begin
                            done_next = 1'b1;
                            if (cat_full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                cat_we          = 1'b1;
                                cat_tail_next   = ptr_inc(cat_tail_reg);
                                cat_count_next  = cat_count_reg + 1'b1;
                                counter_next    = counter_reg + 32'd1;
                                rsp_next.status = ST_ENQUEUED;
                            end
                        end
                        OP_DEQ_DOG:
                        begin
                            if (dog_empty)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = BK_READ;
                            end
                        end
                        OP_DEQ_CAT:
                        begin
                            if (cat_empty)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = BK_READ;
                            end
                        end
                        OP_DEQ_ANY:
                        begin
                            if (dog_empty && cat_empty)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = BK_READ;
                            end
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_REJECTED;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                // head data comes out of the rams' registered read in the cycle after the pop decision
                done_next          = 1'b1;
                rsp_next.status    = ST_DEQUEUED;
                rsp_next.out_name  = taken.name;
                rsp_next.out_stamp = taken.stamp;
                rsp_next.out_kind  = take_cat;
                if (take_cat)
                begin
                    cat_head_next  = ptr_inc(cat_head_reg);
                    cat_count_next = cat_count_reg - 1'b1;
                end
                else
                begin
                    dog_head_next  = ptr_inc(dog_head_reg);
                    dog_count_next = dog_count_reg - 1'b1;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            dog_head_reg  <= '0;
            dog_tail_reg  <= '0;
            cat_head_reg  <= '0;
            cat_tail_reg  <= '0;
            dog_count_reg <= '0;
            cat_count_reg <= '0;
            counter_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dog_head_reg  <= dog_head_next;
            dog_tail_reg  <= dog_tail_next;
            cat_head_reg  <= cat_head_next;
            cat_tail_reg  <= cat_tail_next;
            dog_count_reg <= dog_count_next;
            cat_count_reg <= cat_count_next;
            counter_reg   <= counter_next;
            done_reg      <= done_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
